/* rtl/snfs_pkg.sv */
`timescale 1ns / 1ps
package snfs_pkg;

    localparam int NodeCountDef = 2;
    localparam int PageSizeDef  = 256;
    localparam int SectorSize   = 4096;

    localparam logic [2:0] F_DETECT  = 3'd0;
    localparam logic [2:0] F_READ    = 3'd1;
    localparam logic [2:0] F_PROGRAM = 3'd2;
    localparam logic [2:0] F_ERASE   = 3'd3;
    localparam logic [2:0] F_REPLY   = 3'd4;
    localparam logic [2:0] F_DATA    = 3'd5;

    localparam logic [1:0] K_XFER = 2'd0;
    localparam logic [1:0] K_RDAT = 2'd1;
    localparam logic [1:0] K_DREQ = 2'd2;
    localparam logic [1:0] K_DONE = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOCHIP  = 3'd1;
    localparam logic [2:0] ST_UNALIGN = 3'd2;
    localparam logic [2:0] ST_DEVERR  = 3'd3;
    localparam logic [2:0] ST_TIMEOUT = 3'd4;
    localparam logic [2:0] ST_UNKNOWN = 3'd5;
    localparam logic [2:0] ST_ABSENT  = 3'd6;

    localparam logic [7:0] CMD_JEDEC = 8'h9F;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_PROG  = 8'h02;
    localparam logic [7:0] CMD_ERASE = 8'h20;
    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] CMD_WREN  = 8'h06;

    localparam logic [2:0] REG_POLL  = 3'd0;
    localparam logic [2:0] REG_C0V   = 3'd1;
    localparam logic [2:0] REG_C0D   = 3'd2;
    localparam logic [2:0] REG_C1V   = 3'd3;
    localparam logic [2:0] REG_C1D   = 3'd4;

    localparam logic [19:0] PollLimitRst = 20'd100000;

    typedef struct packed {
        logic [2:0]  func;
        logic [2:0]  channel;
        logic [23:0] address;
        logic [15:0] length;
        logic [7:0]  reply_byte;
        logic [7:0]  data_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  spi_select;
        logic [7:0]  mosi_byte;
        logic        cs_release;
        logic [7:0]  read_byte;
        logic [2:0]  status;
        logic [15:0] byte_count;
        logic        chip_index;
        logic        last;
    } t_result;

endpackage

/* rtl/snfs_front.sv */
`timescale 1ns / 1ps
// Input side: drops items that cannot matter and queues the rest.
module snfs_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  snfs_pkg::t_item  i_item,
    output logic             o_valid,
    input  logic             i_ready,
    output snfs_pkg::t_item  o_item
);
    logic [1:0]      r_cnt;
    logic            r_rp, r_wp;
    snfs_pkg::t_item r_mem [2];
    logic            w_in, w_out, w_keep;

    // func 6 and 7 never do anything
    assign w_keep  = (i_item.func <= snfs_pkg::F_DATA);
    assign o_ready = (r_cnt != 2'd2);
    assign w_in    = i_valid && o_ready && w_keep;
    assign o_valid = (r_cnt != 2'd0);
    assign w_out   = o_valid && i_ready;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rp  <= 1'b0;
            r_wp  <= 1'b0;
        end else begin
            if (w_in) r_wp <= ~r_wp;
            if (w_out) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_in} - {1'b0, w_out};
        end
        if (w_in) r_mem[r_wp] <= i_item;
    end
endmodule

/* rtl/snfs_back.sv */
`timescale 1ns / 1ps
// Sequencer: carries out one queued item per cycle when no earlier results are waiting, emitting up to two results.
module snfs_back #(
    parameter int NODE_COUNT = snfs_pkg::NodeCountDef,
    parameter int PAGE_SIZE  = snfs_pkg::PageSizeDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  snfs_pkg::t_item   i_item,
    input  logic [19:0]       i_poll_limit,
    input  logic [7:0]        i_c0v,
    input  logic [15:0]       i_c0d,
    input  logic [7:0]        i_c1v,
    input  logic [15:0]       i_c1d,
    output logic              o_valid,
    input  logic              i_ready,
    output snfs_pkg::t_result o_res
);
    localparam int PW = $clog2(PAGE_SIZE);
    localparam int SW = $clog2(snfs_pkg::SectorSize);
    localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DET, S_RD_HDR, S_RD_DATA, S_WEL, S_ER_HDR,
        S_POLL_CMD, S_POLL_RD, S_PG_HDR, S_PG_WANT, S_PG_DATA
    } t_phase;

    t_phase      r_ph, n_ph;
    logic [NODE_COUNT-1:0] r_node, n_node;
    logic [1:0]  r_op, n_op;
    logic [2:0]  r_ch, n_ch;
    logic [23:0] r_addr, n_addr;
    logic [15:0] r_left, n_left;
    logic [PW:0] r_pgl, n_pgl;
    logic [PW:0] r_chunk, n_chunk;
    logic [19:0] r_poll, n_poll;
    logic [23:0] r_id, n_id;
    logic [1:0]  r_hdr, n_hdr;
    logic        r_ef, n_ef;
    logic [15:0] r_done, n_done;

    // result buffer of three entries; an item fills at most two
    snfs_pkg::t_result r_buf [3];
    snfs_pkg::t_result n_buf [3];
    logic [1:0]  r_bn, r_bi;
    logic [1:0]  n_bn;

    logic w_go;
    // take the next item in the cycle the last buffered result leaves
    assign o_ready = (r_bn == 2'd0) || (i_ready && (r_bi + 2'd1 == r_bn));
    assign w_go    = i_valid && o_ready;
    assign o_valid = (r_bn != 2'd0);
    assign o_res   = r_buf[r_bi];

    function automatic snfs_pkg::t_result mk(logic [1:0] k, logic [2:0] ch, logic [7:0] m,
                                             logic rel, logic [7:0] rd, logic [2:0] st,
                                             logic [15:0] c, logic ci);
        snfs_pkg::t_result r;
        r.kind       = k;
        r.spi_select = (k == snfs_pkg::K_XFER || k == snfs_pkg::K_DREQ) ? ch : 3'd0;
        r.mosi_byte  = m;
        r.cs_release = rel;
        r.read_byte  = rd;
        r.status     = st;
        r.byte_count = c;
        r.chip_index = ci;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic logic [7:0] abyte(logic [23:0] a, logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd1:    b = a[23:16];
            2'd2:    b = a[15:8];
            default: b = a[7:0];
        endcase
        return b;
    endfunction

    always_comb begin
        logic [1:0]  n;
        logic [15:0] left;
        logic [15:0] done;
        logic [PW:0] room;
        logic [7:0]  v, r;
        logic [2:0]  st;
        logic        fin, pg;
        logic [19:0] pc;
        n_ph = r_ph; n_node = r_node; n_op = r_op; n_ch = r_ch; n_addr = r_addr;
        n_left = r_left; n_pgl = r_pgl; n_chunk = r_chunk; n_poll = r_poll;
        n_id = r_id; n_hdr = r_hdr; n_ef = r_ef; n_done = r_done;
        n = 2'd0; left = r_left; done = r_done; room = '0; v = '0; st = '0;
        fin = 1'b0; pg = 1'b0; pc = r_poll;
        r = i_item.reply_byte;
        for (int k = 0; k < 3; k++) n_buf[k] = r_buf[k];

        if (w_go) begin
            if (i_item.func <= snfs_pkg::F_ERASE) begin
                if (r_ph == S_IDLE) begin
                    n_op = i_item.func[1:0]; n_ch = i_item.channel;
                    n_addr = i_item.address; n_left = i_item.length;
                    left = i_item.length;
                    n_done = '0; done = '0; n_hdr = '0;
                    if (32'(i_item.channel) >= NODE_COUNT) begin
                        n_buf[0] = mk(snfs_pkg::K_DONE, 3'd0, 8'd0, 1'b0, 8'd0,
                                      snfs_pkg::ST_ABSENT, 16'd0, 1'b0);
                        n = 2'd1;
                    end else if (i_item.func == snfs_pkg::F_DETECT) begin
                        n_id = '0; n_ph = S_DET;
                        n_buf[0] = mk(snfs_pkg::K_XFER, i_item.channel, snfs_pkg::CMD_JEDEC,
                                      1'b0, 8'd0, 3'd0, 16'd0, 1'b0);
                        n = 2'd1;
                    end else if (!r_node[i_item.channel[NW-1:0]]) begin
                        n_buf[0] = mk(snfs_pkg::K_DONE, 3'd0, 8'd0, 1'b0, 8'd0,
                                      snfs_pkg::ST_NOCHIP, 16'd0, 1'b0);
                        n = 2'd1;
                    end else if (i_item.func == snfs_pkg::F_READ) begin
                        n_ph = S_RD_HDR;
                        n_buf[0] = mk(snfs_pkg::K_XFER, i_item.channel, snfs_pkg::CMD_READ,
                                      1'b0, 8'd0, 3'd0, 16'd0, 1'b0);
                        n = 2'd1;
                    end else if (i_item.func == snfs_pkg::F_ERASE &&
                                 i_item.address[SW-1:0] != '0) begin
                        n_buf[0] = mk(snfs_pkg::K_DONE, 3'd0, 8'd0, 1'b0, 8'd0,
                                      snfs_pkg::ST_UNALIGN, 16'd0, 1'b0);
                        n = 2'd1;
                    end else if (i_item.func == snfs_pkg::F_PROGRAM &&
                                 i_item.address[SW-1:0] != '0) begin
                        pg = 1'b1;
                    end else begin
                        n_ef = (i_item.func == snfs_pkg::F_PROGRAM);
                        n_ph = S_WEL;
                        n_buf[0] = mk(snfs_pkg::K_XFER, i_item.channel, snfs_pkg::CMD_WREN,
                                      1'b1, 8'd0, 3'd0, 16'd0, 1'b0);
                        n = 2'd1;
                    end
                end
            end else if (i_item.func == snfs_pkg::F_REPLY) begin
                case (r_ph)
                    S_DET: begin
                        if (r_hdr != 2'd0) n_id = {r_id[15:0], r};
                        if (r_hdr != 2'd3) begin
                            n_hdr = r_hdr + 2'd1;
                            n_buf[0] = mk(snfs_pkg::K_XFER, r_ch, 8'd0, r_hdr == 2'd2,
                                          8'd0, 3'd0, 16'd0, 1'b0);
                            n = 2'd1;
                        end else begin
                            v = n_id[23:16];
                            n_ph = S_IDLE;
                            n = 2'd1;
                            if (v == 8'h00 || v == 8'hFF)
                                n_buf[0] = mk(snfs_pkg::K_DONE, 3'd0, 8'd0, 1'b0, 8'd0,
                                              snfs_pkg::ST_NOCHIP, 16'd0, 1'b0);
                            else if (v == i_c0v && n_id[15:0] == i_c0d) begin
                                n_node[r_ch[NW-1:0]] = 1'b1;
                                n_buf[0] = mk(snfs_pkg::K_DONE, 3'd0, 8'd0, 1'b0, 8'd0,
                                              snfs_pkg::ST_OK, 16'd0, 1'b0);
                            end else if (v == i_c1v && n_id[15:0] == i_c1d) begin
                                n_node[r_ch[NW-1:0]] = 1'b1;
                                n_buf[0] = mk(snfs_pkg::K_DONE, 3'd0, 8'd0, 1'b0, 8'd0,
                                              snfs_pkg::ST_OK, 16'd0, 1'b1);
                            end else
                                n_buf[0] = mk(snfs_pkg::K_DONE, 3'd0, 8'd0, 1'b0, 8'd0,
                                              snfs_pkg::ST_UNKNOWN, 16'd0, 1'b0);
                        end
                    end
                    S_RD_HDR: begin
                        n = 2'd1;
                        if (r_hdr != 2'd3) begin
                            n_hdr = r_hdr + 2'd1;
                            n_buf[0] = mk(snfs_pkg::K_XFER, r_ch, abyte(r_addr, r_hdr + 2'd1),
                                          r_hdr == 2'd2 && r_left == '0, 8'd0, 3'd0,
                                          16'd0, 1'b0);
                        end else if (r_left == '0) begin
                            n_ph = S_IDLE;
                            n_buf[0] = mk(snfs_pkg::K_DONE, 3'd0, 8'd0, 1'b0, 8'd0,
                                          snfs_pkg::ST_OK, 16'd0, 1'b0);
                        end else begin
                            n_ph = S_RD_DATA;
                            n_buf[0] = mk(snfs_pkg::K_XFER, r_ch, 8'd0, r_left == 16'd1,
                                          8'd0, 3'd0, 16'd0, 1'b0);
                        end
                    end
                    S_RD_DATA: begin
                        n_buf[0] = mk(snfs_pkg::K_RDAT, r_ch, 8'd0, 1'b0, r, 3'd0,
                                      16'd0, 1'b0);
                        n_left = r_left - 16'd1;
                        n_done = r_done + 16'd1;
                        n_addr = r_addr + 24'd1;
                        n = 2'd2;
                        if (n_left != '0)
                            n_buf[1] = mk(snfs_pkg::K_XFER, r_ch, 8'd0, n_left == 16'd1,
                                          8'd0, 3'd0, 16'd0, 1'b0);
                        else begin
                            n_ph = S_IDLE;
                            n_buf[1] = mk(snfs_pkg::K_DONE, 3'd0, 8'd0, 1'b0, 8'd0,
                                          snfs_pkg::ST_OK, n_done, 1'b0);
                        end
                    end
                    S_WEL: begin
                        n_hdr = '0; n = 2'd1;
                        if (r_op == 2'd3 || r_ef) begin
                            n_ph = S_ER_HDR;
                            n_buf[0] = mk(snfs_pkg::K_XFER, r_ch, snfs_pkg::CMD_ERASE, 1'b0,
                                          8'd0, 3'd0, 16'd0, 1'b0);
                        end else begin
                            n_ph = S_PG_HDR;
                            n_buf[0] = mk(snfs_pkg::K_XFER, r_ch, snfs_pkg::CMD_PROG, 1'b0,
                                          8'd0, 3'd0, 16'd0, 1'b0);
                        end
                    end
                    S_ER_HDR, S_PG_HDR: begin
                        n = 2'd1;
                        if (r_hdr != 2'd3) begin
                            n_hdr = r_hdr + 2'd1;
                            n_buf[0] = mk(snfs_pkg::K_XFER, r_ch, abyte(r_addr, r_hdr + 2'd1),
                                          (r_ph == S_ER_HDR) && r_hdr == 2'd2, 8'd0, 3'd0,
                                          16'd0, 1'b0);
                        end else if (r_ph == S_ER_HDR) begin
                            n_poll = '0; n_ph = S_POLL_CMD;
                            n_buf[0] = mk(snfs_pkg::K_XFER, r_ch, snfs_pkg::CMD_RDSR, 1'b0,
                                          8'd0, 3'd0, 16'd0, 1'b0);
                        end else begin
                            n_ph = S_PG_WANT;
                            n_buf[0] = mk(snfs_pkg::K_DREQ, r_ch, 8'd0, 1'b0, 8'd0, 3'd0,
                                          16'd0, 1'b0);
                        end
                    end
                    S_PG_DATA: begin
                        n = 2'd1;
                        if (r_pgl != '0) begin
                            n_ph = S_PG_WANT;
                            n_buf[0] = mk(snfs_pkg::K_DREQ, r_ch, 8'd0, 1'b0, 8'd0, 3'd0,
                                          16'd0, 1'b0);
                        end else begin
                            n_poll = '0; n_ph = S_POLL_CMD;
                            n_buf[0] = mk(snfs_pkg::K_XFER, r_ch, snfs_pkg::CMD_RDSR, 1'b0,
                                          8'd0, 3'd0, 16'd0, 1'b0);
                        end
                    end
                    S_POLL_CMD: begin
                        n_ph = S_POLL_RD; n = 2'd1;
                        n_buf[0] = mk(snfs_pkg::K_XFER, r_ch, 8'd0, 1'b1, 8'd0, 3'd0,
                                      16'd0, 1'b0);
                    end
                    S_POLL_RD: begin
                        if (r_poll != 20'hFFFFF) pc = r_poll + 20'd1;
                        n_poll = pc;
                        fin = 1'b1;
                        if (r[5]) st = snfs_pkg::ST_DEVERR;
                        else if (!r[0]) st = snfs_pkg::ST_OK;
                        else if (pc >= i_poll_limit) st = snfs_pkg::ST_TIMEOUT;
                        else begin
                            fin = 1'b0; n_ph = S_POLL_CMD; n = 2'd1;
                            n_buf[0] = mk(snfs_pkg::K_XFER, r_ch, snfs_pkg::CMD_RDSR, 1'b0,
                                          8'd0, 3'd0, 16'd0, 1'b0);
                        end
                        if (fin) begin
                            n = 2'd1;
                            if (r_op == 2'd3) begin
                                n_ph = S_IDLE;
                                n_buf[0] = mk(snfs_pkg::K_DONE, 3'd0, 8'd0, 1'b0, 8'd0, st,
                                              st == snfs_pkg::ST_OK ?
                                              16'(snfs_pkg::SectorSize) : 16'd0, 1'b0);
                            end else if (st != snfs_pkg::ST_OK) begin
                                n_ph = S_IDLE;
                                n_buf[0] = mk(snfs_pkg::K_DONE, 3'd0, 8'd0, 1'b0, 8'd0, st,
                                              r_done, 1'b0);
                            end else begin
                                if (!r_ef) done = r_done + 16'(r_chunk);
                                n_done = done;
                                n = 2'd0;
                                pg = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end else if (i_item.func == snfs_pkg::F_DATA && r_ph == S_PG_WANT) begin
                n_pgl = r_pgl - (PW+1)'(1);
                n_left = r_left - 16'd1;
                n_addr = r_addr + 24'd1;
                n_ph = S_PG_DATA; n = 2'd1;
                n_buf[0] = mk(snfs_pkg::K_XFER, r_ch, i_item.data_byte, n_pgl == '0,
                              8'd0, 3'd0, 16'd0, 1'b0);
            end

            // open the next page, or finish a program
            if (pg) begin
                n = 2'd1;
                if (left == '0) begin
                    n_ph = S_IDLE;
                    n_buf[0] = mk(snfs_pkg::K_DONE, 3'd0, 8'd0, 1'b0, 8'd0,
                                  snfs_pkg::ST_OK, done, 1'b0);
                end else begin
                    room = (PW+1)'(PAGE_SIZE) - {1'b0, n_addr[PW-1:0]};
                    n_chunk = (left < 16'(room)) ? left[PW:0] : room;
                    n_pgl = n_chunk;
                    n_ef = 1'b0;
                    n_ph = S_WEL;
                    n_buf[0] = mk(snfs_pkg::K_XFER, n_ch, snfs_pkg::CMD_WREN, 1'b1,
                                  8'd0, 3'd0, 16'd0, 1'b0);
                end
            end
            if (n != 2'd0) n_buf[n - 2'd1].last = 1'b1;
        end
        n_bn = n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= S_IDLE; r_node <= '0; r_op <= '0; r_ch <= '0; r_addr <= '0;
            r_left <= '0; r_pgl <= '0; r_chunk <= '0; r_poll <= '0; r_id <= '0;
            r_hdr <= '0; r_ef <= 1'b0; r_done <= '0; r_bn <= '0; r_bi <= '0;
        end else begin
            r_ph <= n_ph; r_node <= n_node; r_op <= n_op; r_ch <= n_ch; r_addr <= n_addr;
            r_left <= n_left; r_pgl <= n_pgl; r_chunk <= n_chunk; r_poll <= n_poll;
            r_id <= n_id; r_hdr <= n_hdr; r_ef <= n_ef; r_done <= n_done;
            if (w_go) begin
                r_bn <= n_bn; r_bi <= '0;
            end else if (o_valid && i_ready) begin
                if (r_bi + 2'd1 == r_bn) begin
                    r_bn <= '0; r_bi <= '0;
                end else r_bi <= r_bi + 2'd1;
            end
        end
        for (int k = 0; k < 3; k++) r_buf[k] <= n_buf[k];
    end
endmodule

/* rtl/spi_nor_flash_sequencer.sv */
`timescale 1ns / 1ps
// SPI NOR flash sequencer. Requests (detect, read, program, erase), SPI replies and
// program data bytes enter on the s_axis side; a two-entry queue feeds the sequencer,
// which takes one item per cycle when no results wait and emits up to two results on
// m_axis (tuser = kind, tlast on the last result of an item). An item arriving while
// results are waiting is held in the queue until they have all been taken.
// Configuration writes go on the cfg channel while idle.
module spi_nor_flash_sequencer #(
    parameter int NODE_COUNT = snfs_pkg::NodeCountDef,
    parameter int PAGE_SIZE  = snfs_pkg::PageSizeDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // func, channel, address, length, reply_byte,
                                       // data_byte (from bit 0)
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // spi_select, mosi_byte, cs_release, read_byte,
                                       // status, byte_count, chip_index (from bit 0)
    output logic [1:0]  m_axis_tuser,  // kind
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);
    snfs_pkg::t_item   w_in, w_q;
    snfs_pkg::t_result w_res;
    logic              w_qv, w_qr;
    logic [19:0]       r_poll_limit;
    logic [7:0]        r_c0v, r_c1v;
    logic [15:0]       r_c0d, r_c1d;

    assign w_in.func       = s_axis_tdata[2:0];
    assign w_in.channel    = s_axis_tdata[5:3];
    assign w_in.address    = s_axis_tdata[29:6];
    assign w_in.length     = s_axis_tdata[45:30];
    assign w_in.reply_byte = s_axis_tdata[53:46];
    assign w_in.data_byte  = s_axis_tdata[61:54];

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= snfs_pkg::PollLimitRst;
            r_c0v <= 8'hC2; r_c0d <= 16'h201A; r_c1v <= 8'h9D; r_c1d <= 16'h6018;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                snfs_pkg::REG_POLL: r_poll_limit <= i_cfg_data;
                snfs_pkg::REG_C0V:  r_c0v <= i_cfg_data[7:0];
                snfs_pkg::REG_C0D:  r_c0d <= i_cfg_data[15:0];
                snfs_pkg::REG_C1V:  r_c1v <= i_cfg_data[7:0];
                snfs_pkg::REG_C1D:  r_c1d <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    snfs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_item(w_q)
    );

    snfs_back #(.NODE_COUNT(NODE_COUNT), .PAGE_SIZE(PAGE_SIZE)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_ready(w_qr), .i_item(w_q),
        .i_poll_limit(r_poll_limit), .i_c0v(r_c0v), .i_c0d(r_c0d),
        .i_c1v(r_c1v), .i_c1d(r_c1d),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(w_res)
    );

    assign m_axis_tuser = w_res.kind;
    assign m_axis_tlast = w_res.last;
    assign m_axis_tdata = {w_res.chip_index, w_res.byte_count, w_res.status,
                           w_res.read_byte, w_res.cs_release, w_res.mosi_byte,
                           w_res.spi_select};
endmodule

/* tb/spi_nor_flash_sequencer_checker.sv */
`timescale 1ns / 1ps
module spi_nor_flash_sequencer_checker
    import snfs_pkg::*;
#(
    parameter int NODE_COUNT = NodeCountDef,
    parameter int PAGE_SIZE  = PageSizeDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [63:0] i_s_data,
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [39:0] i_m_data,
    input  logic [1:0]  i_m_user,
    input  logic        i_m_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_results
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_DET, PH_RD_HDR, PH_RD_DATA, PH_WEL, PH_ER_HDR,
        PH_POLL_CMD, PH_POLL_RD, PH_PG_HDR, PH_PG_WANT, PH_PG_DATA
    } seq_phase_e;

    logic [19:0] poll_limit;
    logic [7:0]  c0_vendor, c1_vendor;
    logic [15:0] c0_device, c1_device;
    logic        node_present [NODE_COUNT];
    seq_phase_e  ph;
    logic [1:0]  op;
    logic [2:0]  cur_ch;
    logic [23:0] cur_addr;
    logic [15:0] bytes_left, done_cnt;
    logic [9:0]  page_left, chunk;
    logic [19:0] poll_cnt;
    logic [23:0] id_shift;
    logic [1:0]  hdr_idx;
    logic        erase_first;
    t_result     flash_results [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_results = 0;
    end

    task automatic report(input string msg);
        if (o_errors < 40) $display("MISMATCH @%0t: %s", $time, msg);
        o_errors++;
    endtask

    task automatic push_result(input logic [1:0] kind, input logic [7:0] mosi,
                               input logic rel, input logic [7:0] rd,
                               input logic [2:0] st, input logic [15:0] cnt,
                               input logic ci);
        t_result r;
        r.kind       = kind;
        r.spi_select = (kind == K_XFER || kind == K_DREQ) ? cur_ch : 3'd0;
        r.mosi_byte  = mosi;
        r.cs_release = rel;
        r.read_byte  = rd;
        r.status     = st;
        r.byte_count = cnt;
        r.chip_index = ci;
        r.last       = 1'b0;
        flash_results.push_back(r);
    endtask

    task automatic xfer(input logic [7:0] mosi, input logic rel);
        push_result(K_XFER, mosi, rel, 8'd0, ST_OK, 16'd0, 1'b0);
    endtask

    task automatic finish_op(input logic [2:0] st, input logic [15:0] cnt, input logic ci);
        ph = PH_IDLE;
        push_result(K_DONE, 8'd0, 1'b0, 8'd0, st, cnt, ci);
    endtask

    function automatic logic [7:0] addr_byte(input logic [1:0] k);
        return (k == 2'd1) ? cur_addr[23:16] : (k == 2'd2) ? cur_addr[15:8] : cur_addr[7:0];
    endfunction

    task automatic begin_page();
        int room;
        if (bytes_left == 0) begin
            finish_op(ST_OK, done_cnt, 1'b0);
        end else begin
            room      = PAGE_SIZE - (int'(cur_addr) % PAGE_SIZE);
            chunk     = (int'(bytes_left) < room) ? bytes_left[9:0] : room[9:0];
            page_left = chunk;
            erase_first = 1'b0;
            ph = PH_WEL;
            xfer(CMD_WREN, 1'b1);
        end
    endtask

    task automatic begin_poll();
        poll_cnt = '0;
        ph = PH_POLL_CMD;
        xfer(CMD_RDSR, 1'b0);
    endtask

    task automatic poll_done(input logic [2:0] st);
        if (op == F_ERASE[1:0]) begin
            finish_op(st, (st == ST_OK) ? 16'(SectorSize) : 16'd0, 1'b0);
        end else if (st != ST_OK) begin
            finish_op(st, done_cnt, 1'b0);
        end else begin
            if (!erase_first) done_cnt += 16'(chunk);
            begin_page();
        end
    endtask

    task automatic start_request(input logic [2:0] func, input logic [2:0] ch,
                                 input logic [23:0] addr, input logic [15:0] len);
        op = func[1:0];
        cur_ch = ch;
        cur_addr = addr;
        bytes_left = len;
        done_cnt = '0;
        hdr_idx = '0;
        if (int'(ch) >= NODE_COUNT) begin
            finish_op(ST_ABSENT, 16'd0, 1'b0);
        end else if (func == F_DETECT) begin
            id_shift = '0;
            ph = PH_DET;
            xfer(CMD_JEDEC, 1'b0);
        end else if (!node_present[ch]) begin
            finish_op(ST_NOCHIP, 16'd0, 1'b0);
        end else if (func == F_READ) begin
            ph = PH_RD_HDR;
            xfer(CMD_READ, 1'b0);
        end else if (func == F_ERASE && addr[11:0] != 0) begin
            finish_op(ST_UNALIGN, 16'd0, 1'b0);
        end else if (func == F_PROGRAM && addr[11:0] != 0) begin
            begin_page();
        end else begin
            erase_first = (func == F_PROGRAM);
            ph = PH_WEL;
            xfer(CMD_WREN, 1'b1);
        end
    endtask

    task automatic take_reply(input logic [7:0] r);
        logic [7:0]  v;
        logic [15:0] d;
        case (ph)
            PH_DET: begin
                if (hdr_idx > 0) id_shift = {id_shift[15:0], r};
                if (hdr_idx < 3) begin
                    hdr_idx++;
                    xfer(8'h00, hdr_idx == 3);
                end else begin
                    v = id_shift[23:16];
                    d = id_shift[15:0];
                    if (v == 8'h00 || v == 8'hFF) begin
                        finish_op(ST_NOCHIP, 16'd0, 1'b0);
                    end else if (v == c0_vendor && d == c0_device) begin
                        node_present[int'(cur_ch) % NODE_COUNT] = 1'b1;
                        finish_op(ST_OK, 16'd0, 1'b0);
                    end else if (v == c1_vendor && d == c1_device) begin
                        node_present[int'(cur_ch) % NODE_COUNT] = 1'b1;
                        finish_op(ST_OK, 16'd0, 1'b1);
                    end else begin
                        finish_op(ST_UNKNOWN, 16'd0, 1'b0);
                    end
                end
            end
            PH_RD_HDR: begin
                if (hdr_idx < 3) begin
                    hdr_idx++;
                    xfer(addr_byte(hdr_idx), hdr_idx == 3 && bytes_left == 0);
                end else if (bytes_left == 0) begin
                    finish_op(ST_OK, 16'd0, 1'b0);
                end else begin
                    ph = PH_RD_DATA;
                    xfer(8'h00, bytes_left == 1);
                end
            end
            PH_RD_DATA: begin
                push_result(K_RDAT, 8'd0, 1'b0, r, ST_OK, 16'd0, 1'b0);
                bytes_left--;
                done_cnt++;
                cur_addr++;
                if (bytes_left > 0) xfer(8'h00, bytes_left == 1);
                else finish_op(ST_OK, done_cnt, 1'b0);
            end
            PH_WEL: begin
                hdr_idx = '0;
                if (op == F_ERASE[1:0] || erase_first) begin
                    ph = PH_ER_HDR;
                    xfer(CMD_ERASE, 1'b0);
                end else begin
                    ph = PH_PG_HDR;
                    xfer(CMD_PROG, 1'b0);
                end
            end
            PH_ER_HDR: begin
                if (hdr_idx < 3) begin
                    hdr_idx++;
                    xfer(addr_byte(hdr_idx), hdr_idx == 3);
                end else begin
                    begin_poll();
                end
            end
            PH_PG_HDR: begin
                if (hdr_idx < 3) begin
                    hdr_idx++;
                    xfer(addr_byte(hdr_idx), 1'b0);
                end else begin
                    ph = PH_PG_WANT;
                    push_result(K_DREQ, 8'd0, 1'b0, 8'd0, ST_OK, 16'd0, 1'b0);
                end
            end
            PH_PG_DATA: begin
                if (page_left > 0) begin
                    ph = PH_PG_WANT;
                    push_result(K_DREQ, 8'd0, 1'b0, 8'd0, ST_OK, 16'd0, 1'b0);
                end else begin
                    begin_poll();
                end
            end
            PH_POLL_CMD: begin
                ph = PH_POLL_RD;
                xfer(8'h00, 1'b1);
            end
            PH_POLL_RD: begin
                if (poll_cnt != 20'hFFFFF) poll_cnt++;
                if (r[5]) poll_done(ST_DEVERR);
                else if (!r[0]) poll_done(ST_OK);
                else if (poll_cnt >= poll_limit) poll_done(ST_TIMEOUT);
                else begin
                    ph = PH_POLL_CMD;
                    xfer(CMD_RDSR, 1'b0);
                end
            end
            default: ;
        endcase
    endtask

    // One accepted item: predict its results and mark the last of them.
    task automatic predict_item(input logic [63:0] d);
        logic [2:0] func;
        int         n0;
        func = d[2:0];
        n0   = flash_results.size();
        if (func <= F_ERASE) begin
            if (ph == PH_IDLE) start_request(func, d[5:3], d[29:6], d[45:30]);
        end else if (func == F_REPLY) begin
            take_reply(d[53:46]);
        end else if (func == F_DATA && ph == PH_PG_WANT) begin
            page_left--;
            bytes_left--;
            cur_addr++;
            ph = PH_PG_DATA;
            xfer(d[61:54], page_left == 0);
        end
        if (flash_results.size() > n0) flash_results[flash_results.size() - 1].last = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task automatic check_result();
        t_result want;
        if (flash_results.size() == 0) begin
            report($sformatf("result kind %0d with nothing expected", i_m_user));
        end else begin
            want = flash_results.pop_front();
            check_field("kind",       16'(i_m_user),        16'(want.kind));
            check_field("spi_select", 16'(i_m_data[2:0]),   16'(want.spi_select));
            check_field("mosi_byte",  16'(i_m_data[10:3]),  16'(want.mosi_byte));
            check_field("cs_release", 16'(i_m_data[11]),    16'(want.cs_release));
            check_field("read_byte",  16'(i_m_data[19:12]), 16'(want.read_byte));
            check_field("status",     16'(i_m_data[22:20]), 16'(want.status));
            check_field("byte_count", i_m_data[38:23],      want.byte_count);
            check_field("chip_index", 16'(i_m_data[39]),    16'(want.chip_index));
            check_field("last",       16'(i_m_last),        16'(want.last));
        end
        o_results++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            poll_limit = PollLimitRst;
            c0_vendor = 8'hC2;
            c0_device = 16'h201A;
            c1_vendor = 8'h9D;
            c1_device = 16'h6018;
            for (int i = 0; i < NODE_COUNT; i++) node_present[i] = 1'b0;
            ph = PH_IDLE;
            op = '0;
            cur_ch = '0;
            cur_addr = '0;
            bytes_left = '0;
            done_cnt = '0;
            page_left = '0;
            chunk = '0;
            poll_cnt = '0;
            id_shift = '0;
            hdr_idx = '0;
            erase_first = 1'b0;
            flash_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_POLL: poll_limit = i_cfg_data;
                    REG_C0V:  c0_vendor  = i_cfg_data[7:0];
                    REG_C0D:  c0_device  = i_cfg_data[15:0];
                    REG_C1V:  c1_vendor  = i_cfg_data[7:0];
                    REG_C1D:  c1_device  = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_m_valid && i_m_ready) check_result();
            if (i_s_valid && i_s_ready) predict_item(i_s_data);
        end
        o_pending = flash_results.size();
    end

endmodule

/* tb/spi_nor_flash_sequencer_tb.sv */
`timescale 1ns / 1ps
module spi_nor_flash_sequencer_tb;
    import snfs_pkg::*;

    localparam int StallLimit = 5000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [19:0] i_cfg_data;

    int          errors, pending, results;
    int          items, ignored_items, wait_mark;
    int          last_cnt = 0;
    int          quiet_cycles = 0;
    int          op_count [4];
    logic [1:0]  last_kind = K_XFER;
    logic [7:0]  last_mosi = '0;
    logic        last_rel = 1'b0;
    logic [19:0] cfg_copy [5];
    bit          steady;

    spi_nor_flash_sequencer u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    spi_nor_flash_sequencer_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_axis_tvalid),
        .i_s_ready  (s_axis_tready),
        .i_s_data   (s_axis_tdata),
        .i_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .i_m_data   (m_axis_tdata),
        .i_m_user   (m_axis_tuser),
        .i_m_last   (m_axis_tlast),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_results  (results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 32);
    end

    // Track the last result of each item so the flash side can answer it.
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready && m_axis_tlast) begin
            last_cnt  <= last_cnt + 1;
            last_kind <= m_axis_tuser;
            last_mosi <= m_axis_tdata[10:3];
            last_rel  <= m_axis_tdata[11];
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
            $display("spi_nor_flash_sequencer verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] pack_item(input logic [2:0] func, input logic [2:0] ch,
                                              input logic [23:0] addr, input logic [15:0] len,
                                              input logic [7:0] rb, input logic [7:0] db);
        return {2'b00, db, rb, len, addr, ch, func};
    endfunction

    function automatic logic [63:0] rand_item(input logic [2:0] func);
        return pack_item(func, 3'($urandom), 24'($urandom), 16'($urandom),
                         8'($urandom), 8'($urandom));
    endfunction

    task automatic send(input logic [63:0] d);
        wait_mark = last_cnt;
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        s_axis_tvalid <= 1'b0;
        items++;
    endtask

    task automatic sender_gap();
        if (!steady && $urandom_range(99) < 32) repeat ($urandom_range(1, 4)) @(posedge i_clk);
    endtask

    task automatic await_result();
        while (last_cnt == wait_mark) @(posedge i_clk);
    endtask

    // Inject an item the block must ignore in its present state.
    task automatic maybe_noise(input bit awaiting_reply);
        int sel;
        if ($urandom_range(99) < 6) begin
            sel = $urandom_range(0, 2);
            if (sel == 0) send(rand_item(3'($urandom_range(6, 7))));
            else if (sel == 1) send(rand_item(3'($urandom_range(0, 3))));
            else send(rand_item(awaiting_reply ? F_DATA : F_REPLY));
            ignored_items++;
            @(posedge i_clk);
        end
    endtask

    function automatic logic [7:0] status_byte(input bit force_error);
        logic [7:0] r;
        int         p;
        r = 8'($urandom);
        p = $urandom_range(99);
        if (force_error || p >= 90) begin
            r[5] = 1'b1;
        end else begin
            r[5] = 1'b0;
            r[0] = (p >= 55);
        end
        return r;
    endfunction

    function automatic logic [23:0] pick_id(input int sel);
        case (sel)
            0: return {cfg_copy[REG_C0V][7:0], cfg_copy[REG_C0D][15:0]};
            1: return {cfg_copy[REG_C1V][7:0], cfg_copy[REG_C1D][15:0]};
            3: return {8'h00, 16'($urandom)};
            4: return {8'hFF, 16'($urandom)};
            default: return 24'($urandom);
        endcase
    endfunction

    // Run one request to its completion, acting as the flash and the host.
    task automatic run_op(input logic [2:0] func, input logic [2:0] ch,
                          input logic [23:0] addr, input logic [15:0] len,
                          input int id_sel, input bit force_error);
        logic [23:0] id;
        logic [7:0]  r, prev_mosi;
        int          n_xfer;
        bit          done;
        id = pick_id(id_sel);
        n_xfer = 0;
        prev_mosi = 8'h00;
        done = 0;
        op_count[func[1:0]]++;
        send(pack_item(func, ch, addr, len, 8'($urandom), 8'($urandom)));
        while (!done) begin
            await_result();
            if (last_kind == K_XFER) begin
                n_xfer++;
                r = 8'($urandom);
                if (func == F_DETECT) begin
                    if (n_xfer == 2) r = id[23:16];
                    else if (n_xfer == 3) r = id[15:8];
                    else if (n_xfer == 4) r = id[7:0];
                end else if (prev_mosi == CMD_RDSR && last_mosi == 8'h00 && last_rel) begin
                    r = status_byte(force_error);
                end
                prev_mosi = last_mosi;
                maybe_noise(1'b1);
                sender_gap();
                send(pack_item(F_REPLY, 3'($urandom), 24'($urandom), 16'($urandom), r,
                               8'($urandom)));
            end else if (last_kind == K_DREQ) begin
                maybe_noise(1'b0);
                sender_gap();
                send(rand_item(F_DATA));
            end else begin
                done = 1;
            end
        end
        sender_gap();
    endtask

    task automatic random_op();
        logic [2:0]  func, ch;
        logic [23:0] addr;
        logic [15:0] len;
        int          p, id_sel;
        p = $urandom_range(99);
        func = (p < 15) ? F_DETECT : (p < 45) ? F_READ : (p < 80) ? F_PROGRAM : F_ERASE;
        ch = ($urandom_range(99) < 85) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
        case ($urandom_range(0, 3))
            0: addr = {12'($urandom), 12'h000};
            1: addr = {16'($urandom), 4'hF, 4'($urandom)};
            2: addr = 24'($urandom);
            default: addr = {16'hFFFF, 8'($urandom)};
        endcase
        if (func == F_READ) len = 16'($urandom_range(0, 8));
        else if (func == F_PROGRAM)
            len = ($urandom_range(99) < 3) ? 16'($urandom_range(240, 270))
                                           : 16'($urandom_range(0, 20));
        else len = 16'($urandom);
        p = $urandom_range(99);
        id_sel = (p < 40) ? 0 : (p < 75) ? 1 : (p < 85) ? 2 : (p < 92) ? 3 : 4;
        run_op(func, ch, addr, len, id_sel, 1'b0);
    endtask

    task automatic settle();
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [19:0] val);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_copy[idx] = val;
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        steady = 0;
        items = 0;
        ignored_items = 0;
        wait_mark = 0;
        op_count = '{0, 0, 0, 0};
        cfg_copy = '{PollLimitRst, 20'hC2, 20'h201A, 20'h9D, 20'h6018};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty nodes, absent channel, ignored items, ids, wrap, alignment.
        run_op(F_READ, 3'd0, 24'hFFFFFF, 16'hFFFF, 0, 1'b0);
        run_op(F_ERASE, 3'd7, 24'hFFFFFF, 16'hFFFF, 0, 1'b0);
        send(pack_item(3'd7, 3'd7, 24'hFFFFFF, 16'hFFFF, 8'hFF, 8'hFF));
        @(posedge i_clk);
        send(rand_item(3'd6));
        @(posedge i_clk);
        send(rand_item(F_REPLY));
        @(posedge i_clk);
        send(rand_item(F_DATA));
        ignored_items += 4;
        @(posedge i_clk);
        run_op(F_DETECT, 3'd0, 24'h0, 16'h0, 0, 1'b0);
        run_op(F_DETECT, 3'd1, 24'h0, 16'h0, 2, 1'b0);
        run_op(F_DETECT, 3'd1, 24'h0, 16'h0, 3, 1'b0);
        run_op(F_DETECT, 3'd1, 24'h0, 16'h0, 4, 1'b0);
        run_op(F_DETECT, 3'd1, 24'h0, 16'h0, 1, 1'b0);
        run_op(F_DETECT, 3'd2, 24'h0, 16'h0, 0, 1'b0);
        run_op(F_READ, 3'd0, 24'h000000, 16'h0, 0, 1'b0);
        run_op(F_READ, 3'd1, 24'hFFFFFE, 16'd3, 0, 1'b0);
        run_op(F_ERASE, 3'd0, 24'h001001, 16'h0, 0, 1'b0);
        run_op(F_ERASE, 3'd1, 24'hFFF000, 16'h0, 0, 1'b0);
        run_op(F_ERASE, 3'd0, 24'h002000, 16'h0, 0, 1'b1);
        run_op(F_PROGRAM, 3'd0, 24'h0000FE, 16'd4, 0, 1'b0);
        run_op(F_PROGRAM, 3'd1, 24'h003000, 16'd0, 0, 1'b0);
        run_op(F_PROGRAM, 3'd0, 24'h004000, 16'hFFFF, 0, 1'b1);

        while (items < 130) random_op();

        write_cfg(REG_POLL, 20'd1);
        write_cfg(REG_C0V, {12'($urandom), 8'h01});
        write_cfg(REG_C0D, {4'($urandom), 16'h0000});
        write_cfg(REG_C1V, {12'($urandom), 8'hFE});
        write_cfg(REG_C1D, {4'($urandom), 16'hFFFF});
        run_op(F_DETECT, 3'd0, 24'h0, 16'h0, 0, 1'b0);
        run_op(F_DETECT, 3'd1, 24'h0, 16'h0, 1, 1'b0);
        steady = 1;
        while (items < 230) random_op();
        steady = 0;

        write_cfg(REG_POLL, 20'd0);
        run_op(F_ERASE, 3'd0, 24'h005000, 16'h0, 0, 1'b0);
        run_op(F_PROGRAM, 3'd1, 24'h006000, 16'd2, 0, 1'b0);
        write_cfg(REG_POLL, 20'hFFFFF);
        write_cfg(REG_C0V, 20'($urandom));
        write_cfg(REG_C0D, 20'($urandom));
        write_cfg(REG_C1V, 20'h00080);
        write_cfg(REG_C1D, 20'h08000);
        run_op(F_DETECT, 3'd0, 24'h0, 16'h0, 1, 1'b0);
        run_op(F_DETECT, 3'd1, 24'h0, 16'h0, 0, 1'b0);
        while (items < 330) random_op();

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("run: %0d items (%0d ignored), %0d results checked", items, ignored_items,
                 results);
        $display("requests: %0d detect, %0d read, %0d program, %0d erase; poll limits 0,1,max",
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        if (errors == 0) begin
            $display("spi_nor_flash_sequencer verification clean");
        end else begin
            $display("spi_nor_flash_sequencer verification failed");
        end
        $finish;
    end

endmodule
